// ----- rtl/core/sgm_pkg.sv -----
// Shared widths, register codes and helpers for the Sobel gradient magnitude block.
package sgm_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	localparam int PIX_W      = 8;
	localparam int GRAD_W     = 10;
	localparam int SQ_W       = 20;
	localparam int MAG_W      = 21;
	localparam int POS_W      = 10;
	localparam int CFG_W      = 11;
	localparam int CFG_IDX_W  = 1;
	localparam int OUT_BITS   = 3 * GRAD_W + GRAD_W + 2 * MAG_W + 2 * POS_W;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
	localparam int IN_DATA_W  = ((PIX_W + 7) / 8) * 8;

	localparam logic [CFG_W-1:0] WIDTH_RST  = 11'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RST = 11'd480;
	localparam logic [CFG_W-1:0] DIM_MIN    = 11'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v, input int hi);
		logic [CFG_W-1:0] r;
		if (v < DIM_MIN) begin
			r = DIM_MIN;
		end else if (int'(v) > hi) begin
			r = CFG_W'(hi);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/sobel_gradient_magnitude.sv -----
// Streaming 3x3 Sobel edge detector: gradients, squared magnitude and per-frame peaks.
// Throughput: one pixel per cycle while the output is not stalled by m_axis_tready.
// Stages: line memory read, gradient and X/Y peaks, squares, magnitude sum and its peak.
// Border pixels (first two rows and columns) produce no result; last interior one sets tlast.
// Reset clears counters, window, peaks and valid flags; line memories are not cleared.
// A configuration write clamps the value and restarts the frame at row 0, column 0.
module sobel_gradient_magnitude
	import sgm_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // pixel
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// gx_abs, gy_abs, magnitude_sq, peak_gx, peak_gy, peak_magnitude, centre_row, centre_col
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic                  m_axis_tlast   // frame_end
);

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam logic [CFG_W-1:0] WIDTH_INIT  = clamp_dim(WIDTH_RST, MAX_WIDTH);
	localparam logic [CFG_W-1:0] HEIGHT_INIT = clamp_dim(HEIGHT_RST, MAX_HEIGHT);

	function automatic logic [GRAD_W-1:0] abs_diff(input logic [GRAD_W-1:0] a,
			input logic [GRAD_W-1:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	function automatic logic [GRAD_W-1:0] wsum(input logic [PIX_W-1:0] a,
			input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] c);
		return GRAD_W'(a) + GRAD_W'({b, 1'b0}) + GRAD_W'(c);
	endfunction

	// configuration and position
	logic [CFG_W-1:0] width_q, height_q;
	logic [CW-1:0]    col_q;
	logic [RW-1:0]    row_q;
	logic             last_col, last_row, accept;

	// pipeline control
	logic v1_s1, v2_s2, v3_s3, v4_s4;
	logic rdy1, rdy2, rdy3, rdy4, adv1;

	// stage 1
	logic [PIX_W-1:0] pix_s1, top_s1, mid_s1;
	logic [CW-1:0]    col_s1;
	logic             inner_s1, first_s1, end_s1;
	logic [POS_W-1:0] crow_s1, ccol_s1;

	// window: column c-2 (t0,m0,b0) and c-1 (t1,m1,b1)
	logic [PIX_W-1:0] t0_q, m0_q, b0_q, t1_q, m1_q, b1_q;

	// peaks
	logic [GRAD_W-1:0] pgx_q, pgy_q;
	logic [MAG_W-1:0]  pmag_q;
	logic              clr_pend_q;

	// stage 2..4
	logic [GRAD_W-1:0] gx, gy, pgx_base, pgy_base, pgx_nxt, pgy_nxt;
	logic [GRAD_W-1:0] gx_s2, gy_s2, pgx_s2, pgy_s2;
	logic [POS_W-1:0]  crow_s2, ccol_s2, crow_s3, ccol_s3, crow_s4, ccol_s4;
	logic              end_s2, end_s3, end_s4, clr_s2, clr_s3;
	logic [GRAD_W-1:0] gx_s3, gy_s3, pgx_s3, pgy_s3, gx_s4, gy_s4, pgx_s4, pgy_s4;
	logic [SQ_W-1:0]   sqx_s3, sqy_s3;
	logic [MAG_W-1:0]  mag, pmag_base, pmag_nxt, mag_s4, pmag_s4;

	assign rdy4 = !v4_s4 || m_axis_tready;
	assign rdy3 = !v3_s3 || rdy4;
	assign rdy2 = !v2_s2 || rdy3;
	assign rdy1 = !v1_s1 || rdy2;
	assign adv1 = v1_s1 && rdy2;

	assign s_axis_tready = rdy1;
	assign accept        = s_axis_tvalid && rdy1;

	assign last_col = (32'(col_q) + 32'd1) >= 32'(width_q);
	assign last_row = (32'(row_q) + 32'd1) >= 32'(height_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_INIT;
			height_q <= HEIGHT_INIT;
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH:  width_q  <= clamp_dim(cfg_data, MAX_WIDTH);
				REG_IMAGE_HEIGHT: height_q <= clamp_dim(cfg_data, MAX_HEIGHT);
				default: ;
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : RW'(32'(row_q) + 32'd1);
			end else begin
				col_q <= CW'(32'(col_q) + 32'd1);
			end
		end
	end

	sgm_ram #(.DEPTH(MAX_WIDTH), .DATA_W(PIX_W)) u_upper (
		.clk   (clk),
		.we    (adv1),
		.waddr (col_s1),
		.wdata (mid_s1),
		.re    (accept),
		.raddr (col_q),
		.rdata (top_s1)
	);

	sgm_ram #(.DEPTH(MAX_WIDTH), .DATA_W(PIX_W)) u_middle (
		.clk   (clk),
		.we    (adv1),
		.waddr (col_s1),
		.wdata (pix_s1),
		.re    (accept),
		.raddr (col_q),
		.rdata (mid_s1)
	);

	// stage 1: hold request and position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
		end else if (rdy1) begin
			v1_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1   <= s_axis_tdata[PIX_W-1:0];
			col_s1   <= col_q;
			inner_s1 <= (32'(row_q) >= 32'd2) && (32'(col_q) >= 32'd2);
			first_s1 <= (row_q == '0) && (col_q == '0);
			end_s1   <= last_row && last_col;
			crow_s1  <= POS_W'(32'(row_q) - 32'd1);
			ccol_s1  <= POS_W'(32'(col_q) - 32'd1);
		end
	end

	// window shift and X/Y peaks
	assign gx = abs_diff(wsum(top_s1, mid_s1, pix_s1), wsum(t0_q, m0_q, b0_q));
	assign gy = abs_diff(wsum(t0_q, t1_q, top_s1), wsum(b0_q, b1_q, pix_s1));
	assign pgx_base = clr_pend_q ? '0 : pgx_q;
	assign pgy_base = clr_pend_q ? '0 : pgy_q;
	assign pgx_nxt  = (gx > pgx_base) ? gx : pgx_base;
	assign pgy_nxt  = (gy > pgy_base) ? gy : pgy_base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t0_q       <= '0;
			m0_q       <= '0;
			b0_q       <= '0;
			t1_q       <= '0;
			m1_q       <= '0;
			b1_q       <= '0;
			pgx_q      <= '0;
			pgy_q      <= '0;
			clr_pend_q <= 1'b0;
		end else if (adv1) begin
			t0_q <= t1_q;
			m0_q <= m1_q;
			b0_q <= b1_q;
			t1_q <= top_s1;
			m1_q <= mid_s1;
			b1_q <= pix_s1;
			if (first_s1) begin
				clr_pend_q <= 1'b1;
			end else if (inner_s1) begin
				clr_pend_q <= 1'b0;
				pgx_q      <= pgx_nxt;
				pgy_q      <= pgy_nxt;
			end
		end
	end

	// stage 2: gradients
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_s2 <= 1'b0;
		end else if (rdy2) begin
			v2_s2 <= v1_s1 && inner_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2) begin
			gx_s2   <= gx;
			gy_s2   <= gy;
			pgx_s2  <= pgx_nxt;
			pgy_s2  <= pgy_nxt;
			clr_s2  <= clr_pend_q;
			crow_s2 <= crow_s1;
			ccol_s2 <= ccol_s1;
			end_s2  <= end_s1;
		end
	end

	// stage 3: squares
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3_s3 <= 1'b0;
		end else if (rdy3) begin
			v3_s3 <= v2_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3) begin
			sqx_s3  <= gx_s2 * gx_s2;
			sqy_s3  <= gy_s2 * gy_s2;
			gx_s3   <= gx_s2;
			gy_s3   <= gy_s2;
			pgx_s3  <= pgx_s2;
			pgy_s3  <= pgy_s2;
			clr_s3  <= clr_s2;
			crow_s3 <= crow_s2;
			ccol_s3 <= ccol_s2;
			end_s3  <= end_s2;
		end
	end

	// stage 4: magnitude and its peak
	assign mag       = MAG_W'(sqx_s3) + MAG_W'(sqy_s3);
	assign pmag_base = clr_s3 ? '0 : pmag_q;
	assign pmag_nxt  = (mag > pmag_base) ? mag : pmag_base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v4_s4  <= 1'b0;
			pmag_q <= '0;
		end else if (rdy4) begin
			v4_s4 <= v3_s3;
			if (v3_s3) begin
				pmag_q <= pmag_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4) begin
			gx_s4   <= gx_s3;
			gy_s4   <= gy_s3;
			mag_s4  <= mag;
			pgx_s4  <= pgx_s3;
			pgy_s4  <= pgy_s3;
			pmag_s4 <= pmag_nxt;
			crow_s4 <= crow_s3;
			ccol_s4 <= ccol_s3;
			end_s4  <= end_s3;
		end
	end

	assign m_axis_tvalid = v4_s4;
	assign m_axis_tlast  = end_s4;
	assign m_axis_tdata  = OUT_DATA_W'({ccol_s4, crow_s4, pmag_s4, pgy_s4, pgx_s4,
		mag_s4, gy_s4, gx_s4});

	a_peak_grad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (gx_s4 <= pgx_s4) && (gy_s4 <= pgy_s4))
		else $error("gradient above its running peak");

	a_peak_mag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (mag_s4 <= pmag_s4))
		else $error("magnitude above its running peak");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(col_q) < 32'(width_q))
		else $error("column counter beyond image width");

	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (col_q == '0) && (row_q == '0))
		else $error("configuration write did not restart the frame");

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> v1_s1 && v2_s2 && v3_s3 && v4_s4)
		else $error("input stalled with a free pipeline stage");

endmodule

// ----- rtl/core/sgm_ram.sv -----
// Single-write, single-read line memory with registered read data.
module sgm_ram #(
	parameter int DEPTH  = 1024,
	parameter int DATA_W = 8,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- tb/sobel_gradient_magnitude_tb.sv -----
// Self-checking testbench for the streaming Sobel gradient magnitude block.
`timescale 1ns / 100ps

module sobel_gradient_magnitude_tb
	import sgm_pkg::*;
();

	typedef struct packed {
		logic [POS_W-1:0]  col;
		logic [POS_W-1:0]  row;
		logic [MAG_W-1:0]  pmag;
		logic [GRAD_W-1:0] pgy;
		logic [GRAD_W-1:0] pgx;
		logic [MAG_W-1:0]  mag;
		logic [GRAD_W-1:0] gy;
		logic [GRAD_W-1:0] gx;
	} grad_fields_t;

	typedef struct packed {
		logic         frame_end;
		grad_fields_t f;
	} grad_res_t;

	typedef struct {
		logic [PIX_W-1:0] pixel;
		bit               typed;
		grad_res_t        res;
	} dir_row_t;

	localparam grad_res_t GX_EDGE = '{1'b1, '{10'd1, 10'd1, 21'd1040400, 10'd0, 10'd1020,
		21'd1040400, 10'd0, 10'd1020}};
	localparam grad_res_t GY_EDGE = '{1'b1, '{10'd1, 10'd1, 21'd1040400, 10'd1020, 10'd0,
		21'd1040400, 10'd1020, 10'd0}};

	dir_row_t dir_tab [27] = '{
		'{8'd0,   1'b0, '0}, '{8'd0,   1'b0, '0}, '{8'd255, 1'b0, '0},
		'{8'd0,   1'b0, '0}, '{8'd0,   1'b0, '0}, '{8'd255, 1'b0, '0},
		'{8'd0,   1'b0, '0}, '{8'd0,   1'b0, '0}, '{8'd255, 1'b1, GX_EDGE},
		'{8'd255, 1'b0, '0}, '{8'd255, 1'b0, '0}, '{8'd255, 1'b0, '0},
		'{8'd0,   1'b0, '0}, '{8'd0,   1'b0, '0}, '{8'd0,   1'b0, '0},
		'{8'd0,   1'b0, '0}, '{8'd0,   1'b0, '0}, '{8'd0,   1'b1, GY_EDGE},
		'{8'd12,  1'b0, '0}, '{8'd200, 1'b0, '0}, '{8'd37,  1'b0, '0},
		'{8'd255, 1'b0, '0}, '{8'd0,   1'b0, '0}, '{8'd90,  1'b0, '0},
		'{8'd140, 1'b0, '0}, '{8'd66,  1'b0, '0}, '{8'd255, 1'b0, '0}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]      cfg_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tlast;

	logic [PIX_W-1:0] upper_mem  [MAX_WIDTH_DEF];
	logic [PIX_W-1:0] middle_mem [MAX_WIDTH_DEF];
	logic [PIX_W-1:0] win [6];
	int unsigned cur_row, cur_col, peak_gx_r, peak_gy_r, peak_mag_r, img_w, img_h;

	grad_res_t grad_q [$];
	int        n_err = 0;
	int        sink_hold = 0;
	bit        idle_on = 1'b1;

	sobel_gradient_magnitude dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int gap_len();
		int r;
		r = int'($urandom_range(0, 99));
		if (r < 65) return 0;
		if (r < 92) return int'($urandom_range(1, 3));
		if (r < 98) return int'($urandom_range(4, 12));
		return int'($urandom_range(20, 60));
	endfunction

	function automatic int unsigned fit_dim(logic [CFG_W-1:0] v, int unsigned hi);
		if (v < 3) return 3;
		if (v > hi) return hi;
		return 32'(v);
	endfunction

	function automatic void apply_reg(cfg_reg_t idx, logic [CFG_W-1:0] v);
		if (idx == REG_IMAGE_WIDTH) begin
			img_w = fit_dim(v, MAX_WIDTH_DEF);
		end else begin
			img_h = fit_dim(v, MAX_HEIGHT_DEF);
		end
		cur_row = 0;
		cur_col = 0;
	endfunction

	function automatic int unsigned abs_gap(int unsigned a, int unsigned b);
		return (a >= b) ? a - b : b - a;
	endfunction

	function automatic void sobel_predict(input logic [PIX_W-1:0] px, output bit hit,
		output grad_res_t res);
		int unsigned c, r, top, mid, bot, gx, gy, mag, w0, w1, w2, w3, w5;
		c = cur_col;
		r = cur_row;
		bot = 32'(px);
		top = 32'(upper_mem[c]);
		mid = 32'(middle_mem[c]);
		w0 = 32'(win[0]);
		w1 = 32'(win[1]);
		w2 = 32'(win[2]);
		w3 = 32'(win[3]);
		w5 = 32'(win[5]);
		hit = 1'b0;
		res = '0;
		if (r == 0 && c == 0) begin
			peak_gx_r = 0;
			peak_gy_r = 0;
			peak_mag_r = 0;
		end
		if (r >= 2 && c >= 2) begin
			gx = abs_gap(top + 2 * mid + bot, w0 + 2 * w1 + w2);
			gy = abs_gap(w0 + 2 * w3 + top, w2 + 2 * w5 + bot);
			mag = gx * gx + gy * gy;
			if (gx > peak_gx_r) peak_gx_r = gx;
			if (gy > peak_gy_r) peak_gy_r = gy;
			if (mag > peak_mag_r) peak_mag_r = mag;
			res.f.gx = GRAD_W'(gx);
			res.f.gy = GRAD_W'(gy);
			res.f.mag = MAG_W'(mag);
			res.f.pgx = GRAD_W'(peak_gx_r);
			res.f.pgy = GRAD_W'(peak_gy_r);
			res.f.pmag = MAG_W'(peak_mag_r);
			res.f.row = POS_W'(r - 1);
			res.f.col = POS_W'(c - 1);
			res.frame_end = (r + 1 >= img_h) && (c + 1 >= img_w);
			hit = 1'b1;
		end
		win[0] = win[3];
		win[1] = win[4];
		win[2] = win[5];
		win[3] = PIX_W'(top);
		win[4] = PIX_W'(mid);
		win[5] = PIX_W'(bot);
		upper_mem[c] = PIX_W'(mid);
		middle_mem[c] = PIX_W'(bot);
		if (c + 1 >= img_w) begin
			cur_col = 0;
			cur_row = (r + 1 >= img_h) ? 0 : r + 1;
		end else begin
			cur_col = c + 1;
		end
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			n_err++;
		end
	endfunction

	function automatic logic [PIX_W-1:0] draw_pixel(int mode);
		if (mode == 1 && $urandom_range(0, 3) != 0) return $urandom_range(0, 1) ? 8'd255 : 8'd0;
		return PIX_W'($urandom_range(0, 255));
	endfunction

	function automatic logic [CFG_W-1:0] pick_dim();
		if ($urandom_range(0, 9) == 0) return CFG_W'($urandom_range(0, 2));
		return CFG_W'($urandom_range(3, 12));
	endfunction

	task automatic push_pixel(logic [PIX_W-1:0] px, bit typed = 1'b0, grad_res_t typed_res = '0);
		int        gap;
		bit        hit;
		grad_res_t res;
		gap = idle_on ? gap_len() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= px;
		do @(posedge clk); while (!s_axis_tready);
		sobel_predict(px, hit, res);
		if (typed) begin
			grad_q.push_back(typed_res);
		end else if (hit) begin
			grad_q.push_back(res);
		end
	endtask

	task automatic run_pixels(int n, int mode);
		for (int i = 0; i < n; i++) begin
			push_pixel(draw_pixel(mode));
		end
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (grad_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_dims(bit do_w, logic [CFG_W-1:0] wv, bit do_h, logic [CFG_W-1:0] hv);
		wait_idle();
		if (do_w) begin
			cfg_we <= 1'b1;
			cfg_index <= REG_IMAGE_WIDTH;
			cfg_data <= wv;
			@(posedge clk);
			apply_reg(REG_IMAGE_WIDTH, wv);
		end
		if (do_h) begin
			cfg_we <= 1'b1;
			cfg_index <= REG_IMAGE_HEIGHT;
			cfg_data <= hv;
			@(posedge clk);
			apply_reg(REG_IMAGE_HEIGHT, hv);
		end
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk) begin
		grad_res_t want, got;
		if (m_axis_tvalid && m_axis_tready) begin
			got.f = grad_fields_t'(m_axis_tdata[OUT_BITS-1:0]);
			got.frame_end = m_axis_tlast;
			if (grad_q.size() == 0) begin
				$display("%0t unexpected result: expected none, actual %h", $time, got);
				n_err++;
			end else begin
				want = grad_q.pop_front();
				check_field("gx_abs", 32'(want.f.gx), 32'(got.f.gx));
				check_field("gy_abs", 32'(want.f.gy), 32'(got.f.gy));
				check_field("magnitude_sq", 32'(want.f.mag), 32'(got.f.mag));
				check_field("peak_gx", 32'(want.f.pgx), 32'(got.f.pgx));
				check_field("peak_gy", 32'(want.f.pgy), 32'(got.f.pgy));
				check_field("peak_magnitude", 32'(want.f.pmag), 32'(got.f.pmag));
				check_field("centre_row", 32'(want.f.row), 32'(got.f.row));
				check_field("centre_col", 32'(want.f.col), 32'(got.f.col));
				check_field("frame_end", 32'(want.frame_end), 32'(got.frame_end));
			end
		end
		if (sink_hold > 0) begin
			sink_hold--;
			m_axis_tready <= 1'b0;
		end else begin
			sink_hold = idle_on ? gap_len() : 0;
			m_axis_tready <= (sink_hold == 0);
		end
	end

	initial begin
		int  rand_items;
		int  n;
		int  frame_px;
		bit  do_w, do_h;
		for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
			upper_mem[i] = '0;
			middle_mem[i] = '0;
		end
		foreach (win[i]) win[i] = '0;
		cur_row = 0;
		cur_col = 0;
		peak_gx_r = 0;
		peak_gy_r = 0;
		peak_mag_r = 0;
		img_w = 32'(WIDTH_RST);
		img_h = 32'(HEIGHT_RST);
		rand_items = 0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset width: first rows of a default frame
		run_pixels(2 * 640 + 10, 0);

		// clamp low to a 3x3 frame, then walk the directed table
		set_dims(1'b1, 11'd1, 1'b1, 11'd2);
		foreach (dir_tab[i]) begin
			push_pixel(dir_tab[i].pixel, dir_tab[i].typed, dir_tab[i].res);
		end
		s_axis_tvalid <= 1'b0;

		while (rand_items < 540) begin
			idle_on = ($urandom_range(0, 4) != 0);
			do_w = (rand_items == 0) || ($urandom_range(0, 5) != 0);
			do_h = (rand_items == 0) || ($urandom_range(0, 5) != 0);
			if (!do_w && !do_h) do_h = 1'b1;
			set_dims(do_w, pick_dim(), do_h, pick_dim());
			frame_px = int'(img_w * img_h);
			if ($urandom_range(0, 3) == 0) begin
				n = int'($urandom_range(1, frame_px - 1));
			end else begin
				n = frame_px * int'($urandom_range(1, 2));
			end
			run_pixels(n, int'($urandom_range(0, 1)));
			rand_items += n;
		end

		while (grad_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (n_err == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#50_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
